// ===== hdl/dcc_pkg.sv =====
// Shared types, constants and lookup tables for the day-count to calendar-date converter.
package dcc_pkg;

    localparam int DAY_W   = 22;
    localparam int MS_W    = 27;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 56;

    localparam logic [MS_W-1:0] MS_DAY_MAX = 27'd86399999;

    typedef logic [3:0] step_t;

    // Step schedule: date lane splits 400y/100y/4y/1y spans, time lane splits h/m/s.
    localparam step_t STEP_N100    = 4'd3;
    localparam step_t STEP_N4_HI   = 4'd4;
    localparam step_t STEP_N4_LO   = 4'd6;
    localparam step_t STEP_N1      = 4'd7;
    localparam step_t STEP_DATE_END = 4'd8;
    localparam step_t STEP_MIN_HI  = 4'd3;
    localparam step_t STEP_SEC_HI  = 4'd6;
    localparam step_t STEP_LAST    = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  load;
        logic  step_en;
        step_t step;
        logic  finish;
    } cmd_t;

    // Date lane divisor for each radix-4 step
    function automatic logic [DAY_W-1:0] date_div(input step_t s);
        logic [DAY_W-1:0] d;
        case (s)
            4'd0:    d = 22'd2337552;
            4'd1:    d = 22'd584388;
            4'd2:    d = 22'd146097;
            4'd3:    d = 22'd36524;
            4'd4:    d = 22'd23376;
            4'd5:    d = 22'd5844;
            4'd6:    d = 22'd1461;
            4'd7:    d = 22'd365;
            default: d = '0;
        endcase
        return d;
    endfunction

    // Time lane divisor for each radix-4 step
    function automatic logic [MS_W-2:0] time_div(input step_t s);
        logic [MS_W-2:0] d;
        case (s)
            4'd0:    d = 26'd57600000;
            4'd1:    d = 26'd14400000;
            4'd2:    d = 26'd3600000;
            4'd3:    d = 26'd960000;
            4'd4:    d = 26'd240000;
            4'd5:    d = 26'd60000;
            4'd6:    d = 26'd16000;
            4'd7:    d = 26'd4000;
            4'd8:    d = 26'd1000;
            default: d = '0;
        endcase
        return d;
    endfunction

    // Years per unit quotient digit of each date step
    function automatic logic [12:0] year_weight(input step_t s);
        logic [12:0] w;
        case (s)
            4'd0:    w = 13'd6400;
            4'd1:    w = 13'd1600;
            4'd2:    w = 13'd400;
            4'd3:    w = 13'd100;
            4'd4:    w = 13'd64;
            4'd5:    w = 13'd16;
            4'd6:    w = 13'd4;
            4'd7:    w = 13'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    // First zero-based day of year of month idx (0 = January)
    function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] idx);
        logic [DOY_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = '0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11))
        begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

// ===== hdl/day_count_to_calendar_date.sv =====
// Top level: converts a day count and milliseconds of day to calendar date and time of day.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata: day_number, ms_in_day
//  m_*      out  m_tvalid / m_tready  m_tdata: year .. millisecond
//
// One conversion runs from input transfer to result valid as nine radix-4
// divide steps by constants (date and time lanes in parallel), then a month lookup
// that loads the result register. A new input is taken once the previous item has
// moved into the result register; the block does not overlap two conversions.
// The result register holds while m_tvalid=1 and m_tready=0; that stalls only the finish.
// Reset clears the controller and the result valid flag; the datapath needs none.
module day_count_to_calendar_date
    import dcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // day_number[21:0], ms_in_day[48:22], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // year[13:0], month[17:14], day_of_month[22:18],
                                       // hour[27:23], minute[33:28], second[39:34],
                                       // millisecond[49:40], zero pad
);

    cmd_t cmd;

    dcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dcc_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// ===== hdl/dcc_ctrl.sv =====
// Controller state machine: sequences the divide steps and owns the result valid flag.
module dcc_ctrl
    import dcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.step       = step_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_RUN:
            begin
                cmd.step_en = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== hdl/dcc_dp.sv =====
// Datapath: radix-4 constant-divisor lanes for date and time, month lookup, result register.
module dcc_dp
    import dcc_pkg::*;
(
    input  logic             clk,
    input  cmd_t             cmd,
    input  logic [IN_W-1:0]  in_data,
    output logic [OUT_W-1:0] out_data
);

    logic [DAY_W-1:0]  drem_reg, drem_next;
    logic [MS_W-1:0]   trem_reg, trem_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [1:0]        n100_reg, n100_next;
    logic [4:0]        n4_reg, n4_next;
    logic [1:0]        n1_reg, n1_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [5:0]        sec_reg, sec_next;
    logic [OUT_W-1:0]  out_reg, out_next;

    logic [DAY_W+1:0]  dd1, dd2, dd3, dsub, drem_ext;
    logic [1:0]        ddig;
    logic [MS_W:0]     td1, td2, td3, tsub, trem_ext;
    logic [1:0]        tdig;
    logic [12:0]       yw;
    logic [YEAR_W-1:0] yadd;
    logic              date_en;
    logic [MS_W-1:0]   ms_in;

    logic              leap;
    logic [DOY_W-1:0]  doy, mstart;
    logic [3:0]        midx;
    logic [4:0]        dom;

    // Date lane digit
    always_comb
    begin
        dd1      = {2'b00, date_div(cmd.step)};
        dd2      = {dd1[DAY_W:0], 1'b0};
        dd3      = dd1 + dd2;
        drem_ext = {2'b00, drem_reg};
        if (drem_ext >= dd3)
        begin
            ddig = 2'd3;
            dsub = dd3;
        end
        else if (drem_ext >= dd2)
        begin
            ddig = 2'd2;
            dsub = dd2;
        end
        else if (drem_ext >= dd1)
        begin
            ddig = 2'd1;
            dsub = dd1;
        end
        else
        begin
            ddig = 2'd0;
            dsub = '0;
        end
    end

    // Time lane digit
    always_comb
    begin
        td1      = {2'b00, time_div(cmd.step)};
        td2      = {td1[MS_W-1:0], 1'b0};
        td3      = td1 + td2;
        trem_ext = {1'b0, trem_reg};
        if (trem_ext >= td3)
        begin
            tdig = 2'd3;
            tsub = td3;
        end
        else if (trem_ext >= td2)
        begin
            tdig = 2'd2;
            tsub = td2;
        end
        else if (trem_ext >= td1)
        begin
            tdig = 2'd1;
            tsub = td1;
        end
        else
        begin
            tdig = 2'd0;
            tsub = '0;
        end
    end

    always_comb
    begin
        yw = year_weight(cmd.step);
        case (ddig)
            2'd0:    yadd = '0;
            2'd1:    yadd = {1'b0, yw};
            2'd2:    yadd = {yw, 1'b0};
            2'd3:    yadd = {1'b0, yw} + {yw, 1'b0};
            default: yadd = '0;
        endcase
    end

    assign date_en = cmd.step < STEP_DATE_END;
    assign ms_in   = (in_data[DAY_W+MS_W-1:DAY_W] > MS_DAY_MAX) ?
                     MS_DAY_MAX : in_data[DAY_W+MS_W-1:DAY_W];

    // Leap year from the span split: year-1 ends in 3 mod 4, not 99 mod 100 unless 399 mod 400
    assign leap = (n1_reg == 2'd3) && ((n4_reg != 5'd24) || (n100_reg == 2'd3));
    assign doy  = drem_reg[DOY_W-1:0];

    always_comb
    begin
        midx = '0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy >= month_start(leap, 4'(m)))
            begin
                midx = 4'(m);
            end
        end
        mstart = month_start(leap, midx);
        dom    = 5'(doy - mstart) + 5'd1;
    end

    always_comb
    begin
        drem_next = drem_reg;
        trem_next = trem_reg;
        year_next = year_reg;
        n100_next = n100_reg;
        n4_next   = n4_reg;
        n1_next   = n1_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        out_next  = out_reg;
        if (cmd.load)
        begin
            drem_next = in_data[DAY_W-1:0];
            trem_next = ms_in;
            year_next = 14'd1;
        end
        if (cmd.step_en)
        begin
            if (date_en)
            begin
                drem_next = DAY_W'(drem_ext - dsub);
                year_next = year_reg + yadd;
                if (cmd.step == STEP_N100)
                begin
                    n100_next = ddig;
                end
                if ((cmd.step >= STEP_N4_HI) && (cmd.step <= STEP_N4_LO))
                begin
                    n4_next = {n4_reg[2:0], ddig};
                end
                if (cmd.step == STEP_N1)
                begin
                    n1_next = ddig;
                end
            end
            trem_next = MS_W'(trem_ext - tsub);
            if (cmd.step < STEP_MIN_HI)
            begin
                hour_next = {hour_reg[2:0], tdig};
            end
            else if (cmd.step < STEP_SEC_HI)
            begin
                min_next = {min_reg[3:0], tdig};
            end
            else
            begin
                sec_next = {sec_reg[3:0], tdig};
            end
        end
        if (cmd.finish)
        begin
            out_next = {6'd0, trem_reg[9:0], sec_reg, min_reg, hour_reg, dom,
                        midx + 4'd1, year_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg <= drem_next;
        trem_reg <= trem_next;
        year_reg <= year_next;
        n100_reg <= n100_next;
        n4_reg   <= n4_next;
        n1_reg   <= n1_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        out_reg  <= out_next;
    end

    assign out_data = out_reg;

endmodule
